FILE: src/mqll_pkg.sv
// Shared types and field widths for the linked-list multi-queue manager.
`default_nettype none

package mqll_pkg;

	// Widths of the request and response fields.
	localparam int KIND_W   = 2;
	localparam int ID_W     = 8;
	localparam int STATUS_W = 2;

	// Request kinds. The fourth code carries no operation and is answered as a bad id.
	typedef enum logic [KIND_W-1:0] {
		KIND_ENQ  = 2'd0,
		KIND_DEQ  = 2'd1,
		KIND_MOVE = 2'd2
	} kind_t;

	// Response status codes.
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_BAD   = 2'd2
	} status_t;

	// Controller states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_QRD,
		S_ENQ_FIN,
		S_DQ_LINK,
		S_DQ_PREV,
		S_WALK,
		S_MV_CLR,
		S_MV_SRC,
		S_MV_SET,
		S_RESP
	} state_t;

endpackage

`default_nettype wire

FILE: src/mqll_qtab.sv
// Queue table: head and tail pointer of every queue, with per-queue valid bits.
`default_nettype none

module mqll_qtab #(
	parameter int NUM_QUEUES = 16,
	parameter int LINK_W     = 7,
	parameter int QADDR_W    = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               we,
	input  logic [QADDR_W-1:0] waddr,
	input  logic [LINK_W-1:0]  wr_head,
	input  logic [LINK_W-1:0]  wr_tail,
	input  logic [QADDR_W-1:0] raddr,
	output logic [LINK_W-1:0]  rd_head,
	output logic [LINK_W-1:0]  rd_tail
);

	logic [2*LINK_W-1:0]   mem [NUM_QUEUES];
	logic [2*LINK_W-1:0]   rdata_q;
	logic                  rvld_q;
	logic [NUM_QUEUES-1:0] vld_q;
	logic                  fwd;

	// A read of the entry being written in the same cycle returns the new word.
	assign fwd = we && (waddr == raddr);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wr_head, wr_tail};
		end
		if (fwd) begin
			rdata_q <= {wr_head, wr_tail};
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	// A queue that has never been written reads as empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rvld_q <= fwd || vld_q[raddr];
		end
	end

	assign rd_head = rvld_q ? rdata_q[2*LINK_W-1:LINK_W] : '1;
	assign rd_tail = rvld_q ? rdata_q[LINK_W-1:0]        : '1;

endmodule

`default_nettype wire

FILE: src/mqll_links.sv
// Link table: next and previous pointer of every entry.
`default_nettype none

module mqll_links #(
	parameter int NUM_ENTRIES = 64,
	parameter int LINK_W      = 7,
	parameter int LADDR_W     = 6
) (
	input  logic               clk,
	input  logic               nx_we,
	input  logic [LADDR_W-1:0] nx_waddr,
	input  logic [LINK_W-1:0]  nx_wdata,
	input  logic [LADDR_W-1:0] nx_raddr,
	output logic [LINK_W-1:0]  nx_rdata,
	input  logic               pv_we,
	input  logic [LADDR_W-1:0] pv_waddr,
	input  logic [LINK_W-1:0]  pv_wdata
);

	logic [LINK_W-1:0] next_mem [NUM_ENTRIES];
	logic [LINK_W-1:0] prev_mem [NUM_ENTRIES];
	logic [LINK_W-1:0] rdata_q;

	// Write-first read port, so that a list walk sees the link it has just cleared.
	always_ff @(posedge clk) begin
		if (nx_we) begin
			next_mem[nx_waddr] <= nx_wdata;
		end
		if (nx_we && (nx_waddr == nx_raddr)) begin
			rdata_q <= nx_wdata;
		end else begin
			rdata_q <= next_mem[nx_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (pv_we) begin
			prev_mem[pv_waddr] <= pv_wdata;
		end
	end

	assign nx_rdata = rdata_q;

endmodule

`default_nettype wire

FILE: src/mqll_ctrl.sv
// Request sequencer: reads, modifies and writes back the queue and link tables.
`default_nettype none

module mqll_ctrl import mqll_pkg::*; #(
	parameter int NUM_ENTRIES = 64,
	parameter int NUM_QUEUES  = 16,
	parameter int LINK_W      = 7,
	parameter int LADDR_W     = 6,
	parameter int QADDR_W     = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [KIND_W-1:0]   kind,
	input  logic [ID_W-1:0]     queue_id,
	input  logic [ID_W-1:0]     entry_id,
	input  logic [ID_W-1:0]     dest_queue_id,
	output logic                busy,
	output logic                done,
	output logic [ID_W-1:0]     result_entry,
	output logic [STATUS_W-1:0] status,
	output logic                q_we,
	output logic [QADDR_W-1:0]  q_waddr,
	output logic [LINK_W-1:0]   q_wr_head,
	output logic [LINK_W-1:0]   q_wr_tail,
	output logic [QADDR_W-1:0]  q_raddr,
	input  logic [LINK_W-1:0]   rd_head,
	input  logic [LINK_W-1:0]   rd_tail,
	output logic                nx_we,
	output logic [LADDR_W-1:0]  nx_waddr,
	output logic [LINK_W-1:0]   nx_wdata,
	output logic [LADDR_W-1:0]  nx_raddr,
	input  logic [LINK_W-1:0]   nx_rdata,
	output logic                pv_we,
	output logic [LADDR_W-1:0]  pv_waddr,
	output logic [LINK_W-1:0]   pv_wdata
);

	localparam int STEP_W = $clog2(NUM_ENTRIES + 1);
	localparam logic [LINK_W-1:0] LINK_NONE = '1;
	localparam logic [LINK_W-1:0] ENT_LIM   = LINK_W'(NUM_ENTRIES);
	localparam logic [STEP_W-1:0] STEP_LIM  = STEP_W'(NUM_ENTRIES);
	localparam logic [ID_W:0]     QID_LIM   = (ID_W + 1)'(NUM_QUEUES);
	localparam logic [ID_W:0]     EID_LIM   = (ID_W + 1)'(NUM_ENTRIES);

	state_t              state_q, state_d;
	kind_t               kind_q;
	logic [QADDR_W-1:0]  qid_q, did_q;
	logic [LINK_W-1:0]   eid_q, h_q, t_q;
	logic [STEP_W-1:0]   steps_q, steps_n;
	logic [ID_W-1:0]     res_q;
	status_t             st_q;

	kind_t               in_kind;
	logic                accept, id_bad;
	logic                head_ok, tail_ok, q_empty, n_ok, walk_more;

	assign in_kind = kind_t'(kind);
	assign accept  = start && (state_q == S_IDLE);

	always_comb begin
		id_bad = ({1'b0, queue_id} >= QID_LIM);
		unique case (in_kind)
			KIND_ENQ:  id_bad = id_bad || ({1'b0, entry_id} >= EID_LIM);
			KIND_DEQ:  id_bad = id_bad;
			KIND_MOVE: id_bad = id_bad || ({1'b0, dest_queue_id} >= QID_LIM);
			default:   id_bad = 1'b1;
		endcase
	end

	// Pointers outside the entry range stand for the end of a list.
	assign head_ok   = rd_head < ENT_LIM;
	assign tail_ok   = rd_tail < ENT_LIM;
	assign q_empty   = !(head_ok && tail_ok);
	assign n_ok      = nx_rdata < ENT_LIM;
	assign steps_n   = steps_q + 1'b1;
	assign walk_more = n_ok && (steps_n < STEP_LIM);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:    if (accept) begin
				state_d = id_bad ? S_RESP : S_QRD;
			end
			S_QRD: begin
				unique case (kind_q)
					KIND_ENQ:  state_d = S_ENQ_FIN;
					KIND_DEQ:  state_d = head_ok ? S_DQ_LINK : S_RESP;
					KIND_MOVE: state_d = head_ok ? S_WALK : S_MV_CLR;
					default:   state_d = S_RESP;
				endcase
			end
			S_ENQ_FIN: state_d = S_RESP;
			S_DQ_LINK: state_d = n_ok ? S_DQ_PREV : S_RESP;
			S_DQ_PREV: state_d = S_RESP;
			S_WALK:    state_d = walk_more ? S_WALK : S_MV_CLR;
			S_MV_CLR:  state_d = S_MV_SRC;
			S_MV_SRC:  state_d = (head_ok && tail_ok) ? S_MV_SET : S_RESP;
			S_MV_SET:  state_d = S_RESP;
			S_RESP:    state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// Table accesses and handshake outputs.
	always_comb begin
		q_we      = 1'b0;
		q_waddr   = qid_q;
		q_wr_head = LINK_NONE;
		q_wr_tail = LINK_NONE;
		q_raddr   = qid_q;
		nx_we     = 1'b0;
		nx_waddr  = LADDR_W'(h_q);
		nx_wdata  = LINK_NONE;
		nx_raddr  = LADDR_W'(h_q);
		pv_we     = 1'b0;
		pv_waddr  = LADDR_W'(h_q);
		pv_wdata  = LINK_NONE;
		unique case (state_q)
			S_IDLE: begin
				q_raddr = (in_kind == KIND_MOVE) ? QADDR_W'(dest_queue_id)
				                                 : QADDR_W'(queue_id);
			end
			S_QRD: begin
				unique case (kind_q)
					KIND_ENQ: begin
						q_we      = 1'b1;
						q_wr_head = q_empty ? eid_q : rd_head;
						q_wr_tail = eid_q;
						nx_we     = !q_empty;
						nx_waddr  = LADDR_W'(rd_tail);
						nx_wdata  = eid_q;
						pv_we     = 1'b1;
						pv_waddr  = LADDR_W'(eid_q);
						pv_wdata  = q_empty ? LINK_NONE : rd_tail;
					end
					KIND_DEQ: begin
						nx_raddr = LADDR_W'(rd_head);
					end
					KIND_MOVE: begin
						nx_raddr = LADDR_W'(rd_head);
						pv_we    = head_ok;
						pv_waddr = LADDR_W'(rd_head);
					end
					default: begin
					end
				endcase
			end
			S_ENQ_FIN: begin
				nx_we    = 1'b1;
				nx_waddr = LADDR_W'(eid_q);
			end
			S_DQ_LINK: begin
				q_we      = 1'b1;
				q_wr_head = n_ok ? nx_rdata : LINK_NONE;
				q_wr_tail = n_ok ? t_q : LINK_NONE;
				nx_we     = 1'b1;
				pv_we     = 1'b1;
			end
			S_DQ_PREV: begin
				pv_we = 1'b1;
			end
			S_WALK: begin
				nx_we    = 1'b1;
				nx_raddr = LADDR_W'(nx_rdata);
				pv_we    = n_ok;
				pv_waddr = LADDR_W'(nx_rdata);
			end
			S_MV_CLR: begin
				q_we    = 1'b1;
				q_waddr = did_q;
			end
			S_MV_SRC: begin
				q_we = 1'b1;
			end
			S_MV_SET: begin
				q_we      = 1'b1;
				q_waddr   = did_q;
				q_wr_head = h_q;
				q_wr_tail = t_q;
				nx_we     = 1'b1;
				nx_waddr  = LADDR_W'(t_q);
				pv_we     = 1'b1;
			end
			S_RESP: begin
			end
			default: begin
			end
		endcase
		busy         = (state_q != S_IDLE);
		done         = (state_q == S_RESP);
		result_entry = res_q;
		status       = st_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (accept) begin
				kind_q <= in_kind;
				qid_q  <= QADDR_W'(queue_id);
				did_q  <= QADDR_W'(dest_queue_id);
				eid_q  <= LINK_W'(entry_id);
				res_q  <= '0;
				st_q   <= id_bad ? STAT_BAD : STAT_OK;
			end
			S_QRD: begin
				h_q     <= rd_head;
				t_q     <= rd_tail;
				steps_q <= '0;
				if (kind_q == KIND_ENQ) begin
					res_q <= ID_W'(eid_q);
				end else if ((kind_q == KIND_DEQ) && !head_ok) begin
					st_q <= STAT_EMPTY;
				end
			end
			S_DQ_LINK: begin
				res_q <= ID_W'(h_q);
				h_q   <= nx_rdata;
			end
			S_WALK: begin
				h_q     <= nx_rdata;
				steps_q <= steps_n;
			end
			S_MV_SRC: begin
				h_q <= rd_head;
				t_q <= rd_tail;
			end
			default: begin
			end
		endcase
	end

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted without the block turning busy");

	a_bad_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && id_bad) |=> (done && (status == STAT_BAD)))
		else $error("bad request not answered in the following cycle");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (steps_q < STEP_LIM))
		else $error("drain walk ran past the entry count");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !(q_we || nx_we || pv_we))
		else $error("table written while idle");

endmodule

`default_nettype wire

FILE: src/multi_queue_linked_list_manager_top.sv
// Top level of the linked-list multi-queue manager.
// Path from the accepted request to the done strobe: a bad request goes straight to the
// response; the others read the queue table first, and a move then drains the destination
// one entry per cycle (at most NUM_ENTRIES) before it rewrites the two queues.
// A new request is accepted in the cycle after done.
// The receiver cannot stall: result words are presented for one cycle with done.
// Reset is asynchronous, active low: all queues read as empty afterwards, without a sweep.
`default_nettype none

module multi_queue_linked_list_manager_top #(
	parameter int NUM_ENTRIES = 64,
	parameter int NUM_QUEUES  = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] kind,
	input  wire logic [7:0] queue_id,
	input  wire logic [7:0] entry_id,
	input  wire logic [7:0] dest_queue_id,
	output logic            busy,
	output logic            done,
	output logic [7:0]      result_entry,
	output logic [1:0]      status
);

	// Link pointers have room for at least one code above the last entry; all-ones marks the end of a list.
	localparam int LINK_W  = $clog2(NUM_ENTRIES + 1);
	localparam int LADDR_W = $clog2(NUM_ENTRIES);
	localparam int QADDR_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

	logic               q_we;
	logic [QADDR_W-1:0] q_waddr, q_raddr;
	logic [LINK_W-1:0]  q_wr_head, q_wr_tail, rd_head, rd_tail;
	logic               nx_we, pv_we;
	logic [LADDR_W-1:0] nx_waddr, nx_raddr, pv_waddr;
	logic [LINK_W-1:0]  nx_wdata, nx_rdata, pv_wdata;

	// The sequencer runs one request at a time through read, modify and write-back steps.
	mqll_ctrl #(
		.NUM_ENTRIES (NUM_ENTRIES),
		.NUM_QUEUES  (NUM_QUEUES),
		.LINK_W      (LINK_W),
		.LADDR_W     (LADDR_W),
		.QADDR_W     (QADDR_W)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.kind          (kind),
		.queue_id      (queue_id),
		.entry_id      (entry_id),
		.dest_queue_id (dest_queue_id),
		.busy          (busy),
		.done          (done),
		.result_entry  (result_entry),
		.status        (status),
		.q_we          (q_we),
		.q_waddr       (q_waddr),
		.q_wr_head     (q_wr_head),
		.q_wr_tail     (q_wr_tail),
		.q_raddr       (q_raddr),
		.rd_head       (rd_head),
		.rd_tail       (rd_tail),
		.nx_we         (nx_we),
		.nx_waddr      (nx_waddr),
		.nx_wdata      (nx_wdata),
		.nx_raddr      (nx_raddr),
		.nx_rdata      (nx_rdata),
		.pv_we         (pv_we),
		.pv_waddr      (pv_waddr),
		.pv_wdata      (pv_wdata)
	);

	// Head and tail of each queue share one word; valid bits make unwritten queues empty.
	mqll_qtab #(
		.NUM_QUEUES (NUM_QUEUES),
		.LINK_W     (LINK_W),
		.QADDR_W    (QADDR_W)
	) u_qtab (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (q_we),
		.waddr   (q_waddr),
		.wr_head (q_wr_head),
		.wr_tail (q_wr_tail),
		.raddr   (q_raddr),
		.rd_head (rd_head),
		.rd_tail (rd_tail)
	);

	// The link table is only meaningful once written, so it has no reset of its own.
	mqll_links #(
		.NUM_ENTRIES (NUM_ENTRIES),
		.LINK_W      (LINK_W),
		.LADDR_W     (LADDR_W)
	) u_links (
		.clk      (clk),
		.nx_we    (nx_we),
		.nx_waddr (nx_waddr),
		.nx_wdata (nx_wdata),
		.nx_raddr (nx_raddr),
		.nx_rdata (nx_rdata),
		.pv_we    (pv_we),
		.pv_waddr (pv_waddr),
		.pv_wdata (pv_wdata)
	);

endmodule

`default_nettype wire

FILE: test/tb_multi_queue_linked_list_manager_top.sv
// Self-checking testbench for the linked-list multi-queue manager: directed table, then random words.
`timescale 1ns / 100ps

module tb_multi_queue_linked_list_manager_top import mqll_pkg::*;;

	localparam int NUM_ENTRIES = 64;
	localparam int NUM_QUEUES  = 16;

	// The fourth kind code carries no operation; the block must answer it as a bad id.
	localparam logic [1:0] KIND_SPARE = 2'd3;

	// The end-of-list marker in the queue table of this testbench. Anything that is not
	// an entry id reads as the end of a list, so the exact value is of no consequence.
	localparam logic [7:0] LINK_END = 8'hFF;

	// Settling time after the last result: longer than the slowest move, which drains a
	// full destination queue at one cycle per entry.
	localparam int SETTLE_CYCLES = NUM_ENTRIES + 16;

	// Random words per idling phase, roughly 700 in total.
	localparam int WORDS_PER_PHASE = 234;

	// One request word as it is driven onto the ports.
	typedef struct packed {
		logic [1:0] op;
		logic [7:0] qid;
		logic [7:0] eid;
		logic [7:0] did;
	} request_t;

	// One response word.
	typedef struct packed {
		logic [7:0] entry;
		status_t    status;
	} response_t;

	// A row of the directed table. Where known is set, the response is written out in the
	// row itself; otherwise it comes from the queue model below.
	typedef struct packed {
		request_t  rq;
		bit        known;
		response_t want;
	} plan_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic [1:0] kind = 2'd0;
	logic [7:0] queue_id = 8'd0;
	logic [7:0] entry_id = 8'd0;
	logic [7:0] dest_queue_id = 8'd0;
	logic       busy;
	logic       done;
	logic [7:0] result_entry;
	logic [1:0] status;

	// The testbench's own copy of the queue table. Backward links are never read by any
	// operation, so only the forward links are kept. The held flags only steer the random
	// choice of entries towards ones that are not already queued.
	logic [7:0] head_of [NUM_QUEUES];
	logic [7:0] tail_of [NUM_QUEUES];
	logic [7:0] next_of [NUM_ENTRIES];
	bit         held [NUM_ENTRIES];

	// Responses still owed by the block, oldest first.
	response_t owed_responses [$];
	int        mismatch_count = 0;

	// Percentage of cycles in which the sender holds back, phase by phase.
	int sender_idle_pct [3] = '{17, 82, 0};

	// The directed table: empty dequeues and bad ids of every kind first, then the special cases
	// of the move (empty source, a queue moved onto itself, a busy destination) and a double enqueue.
	plan_row_t directed_plan [0:25] = '{
		'{'{KIND_DEQ,   8'd0,   8'd0,   8'd0},   1'b1, '{8'd0,  STAT_EMPTY}},
		'{'{KIND_DEQ,   8'd15,  8'd0,   8'd0},   1'b1, '{8'd0,  STAT_EMPTY}},
		'{'{KIND_DEQ,   8'd16,  8'd0,   8'd0},   1'b1, '{8'd0,  STAT_BAD}},
		'{'{KIND_DEQ,   8'd255, 8'd255, 8'd255}, 1'b1, '{8'd0,  STAT_BAD}},
		'{'{KIND_ENQ,   8'd16,  8'd0,   8'd0},   1'b1, '{8'd0,  STAT_BAD}},
		'{'{KIND_ENQ,   8'd0,   8'd64,  8'd0},   1'b1, '{8'd0,  STAT_BAD}},
		'{'{KIND_ENQ,   8'd255, 8'd255, 8'd0},   1'b1, '{8'd0,  STAT_BAD}},
		'{'{KIND_SPARE, 8'd0,   8'd0,   8'd0},   1'b1, '{8'd0,  STAT_BAD}},
		'{'{KIND_MOVE,  8'd0,   8'd0,   8'd16},  1'b1, '{8'd0,  STAT_BAD}},
		'{'{KIND_MOVE,  8'd255, 8'd0,   8'd255}, 1'b1, '{8'd0,  STAT_BAD}},
		'{'{KIND_ENQ,   8'd0,   8'd0,   8'd0},   1'b1, '{8'd0,  STAT_OK}},
		'{'{KIND_ENQ,   8'd0,   8'd63,  8'd0},   1'b1, '{8'd63, STAT_OK}},
		'{'{KIND_ENQ,   8'd15,  8'd5,   8'd0},   1'b1, '{8'd5,  STAT_OK}},
		'{'{KIND_MOVE,  8'd0,   8'd0,   8'd15},  1'b1, '{8'd0,  STAT_OK}},
		'{'{KIND_DEQ,   8'd0,   8'd0,   8'd0},   1'b1, '{8'd0,  STAT_EMPTY}},
		'{'{KIND_DEQ,   8'd15,  8'd0,   8'd0},   1'b0, '{8'd0,  STAT_OK}},
		'{'{KIND_MOVE,  8'd3,   8'd0,   8'd3},   1'b1, '{8'd0,  STAT_OK}},
		'{'{KIND_ENQ,   8'd3,   8'd7,   8'd0},   1'b1, '{8'd7,  STAT_OK}},
		'{'{KIND_MOVE,  8'd3,   8'd0,   8'd3},   1'b1, '{8'd0,  STAT_OK}},
		'{'{KIND_DEQ,   8'd3,   8'd0,   8'd0},   1'b1, '{8'd0,  STAT_EMPTY}},
		'{'{KIND_MOVE,  8'd4,   8'd0,   8'd15},  1'b1, '{8'd0,  STAT_OK}},
		'{'{KIND_DEQ,   8'd15,  8'd0,   8'd0},   1'b1, '{8'd0,  STAT_EMPTY}},
		'{'{KIND_ENQ,   8'd1,   8'd9,   8'd0},   1'b0, '{8'd0,  STAT_OK}},
		'{'{KIND_ENQ,   8'd2,   8'd9,   8'd0},   1'b0, '{8'd0,  STAT_OK}},
		'{'{KIND_DEQ,   8'd1,   8'd0,   8'd0},   1'b0, '{8'd0,  STAT_OK}},
		'{'{KIND_DEQ,   8'd2,   8'd0,   8'd0},   1'b0, '{8'd0,  STAT_OK}}
	};

	multi_queue_linked_list_manager_top #(
		.NUM_ENTRIES(NUM_ENTRIES),
		.NUM_QUEUES (NUM_QUEUES)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.kind         (kind),
		.queue_id     (queue_id),
		.entry_id     (entry_id),
		.dest_queue_id(dest_queue_id),
		.busy         (busy),
		.done         (done),
		.result_entry (result_entry),
		.status       (status)
	);

	// 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit is_entry(input logic [7:0] x);
		return x < NUM_ENTRIES;
	endfunction

	// Unlinks the head of a queue that is known not to be empty and returns it.
	function automatic logic [7:0] unlink_head(input int q);
		logic [7:0] h;
		logic [7:0] n;
		h = head_of[q];
		n = is_entry(next_of[h]) ? next_of[h] : LINK_END;
		if (is_entry(n)) begin
			head_of[q] = n;
		end else begin
			head_of[q] = LINK_END;
			tail_of[q] = LINK_END;
		end
		next_of[h] = LINK_END;
		held[h] = 1'b0;
		return h;
	endfunction

	// Applies one accepted request word to the queue table and returns the response that
	// the block owes for it.
	function automatic response_t apply_request(input request_t rq);
		response_t  resp;
		logic [7:0] first;
		logic [7:0] last;
		int         steps;
		resp = '{8'd0, STAT_BAD};
		case (rq.op)
			KIND_ENQ: begin
				if (rq.qid < NUM_QUEUES && rq.eid < NUM_ENTRIES) begin
					if (is_entry(tail_of[rq.qid]) && is_entry(head_of[rq.qid])) begin
						next_of[tail_of[rq.qid]] = rq.eid;
					end else begin
						head_of[rq.qid] = rq.eid;
					end
					next_of[rq.eid] = LINK_END;
					tail_of[rq.qid] = rq.eid;
					held[rq.eid] = 1'b1;
					resp = '{rq.eid, STAT_OK};
				end
			end
			KIND_DEQ: begin
				if (rq.qid < NUM_QUEUES) begin
					if (is_entry(head_of[rq.qid])) begin
						resp = '{unlink_head(rq.qid), STAT_OK};
					end else begin
						resp.status = STAT_EMPTY;
					end
				end
			end
			KIND_MOVE: begin
				if (rq.qid < NUM_QUEUES && rq.did < NUM_QUEUES) begin
					// The destination is drained one entry at a time. A double enqueue can
					// leave a loop in the links, so the walk is cut off after one pass over
					// the table.
					steps = 0;
					while (is_entry(head_of[rq.did]) && steps < NUM_ENTRIES) begin
						void'(unlink_head(rq.did));
						steps++;
					end
					head_of[rq.did] = LINK_END;
					tail_of[rq.did] = LINK_END;
					first = head_of[rq.qid];
					last = tail_of[rq.qid];
					head_of[rq.qid] = LINK_END;
					tail_of[rq.qid] = LINK_END;
					if (is_entry(first) && is_entry(last)) begin
						head_of[rq.did] = first;
						tail_of[rq.did] = last;
						next_of[last] = LINK_END;
					end
					resp.status = STAT_OK;
				end
			end
			default: begin
			end
		endcase
		return resp;
	endfunction

	// Most traffic goes to a handful of queues so that lists grow long enough for the
	// drain walk of a move to matter.
	function automatic logic [7:0] pick_queue();
		if ($urandom_range(0, 9) < 7) begin
			return 8'($urandom_range(0, 3));
		end
		return 8'($urandom_range(0, NUM_QUEUES - 1));
	endfunction

	// Usually an entry that is not queued anywhere; now and then any entry at all, which
	// gives the occasional double enqueue.
	function automatic logic [7:0] pick_entry();
		int base;
		base = $urandom_range(0, NUM_ENTRIES - 1);
		if ($urandom_range(0, 9) != 0) begin
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				if (!held[(base + i) % NUM_ENTRIES]) begin
					return 8'((base + i) % NUM_ENTRIES);
				end
			end
		end
		return 8'(base);
	endfunction

	// Mostly well-formed requests with random contents; about one word in eight is pure
	// noise, which mainly exercises the bad-id path and the spare kind code. Fields that
	// the operation ignores are left random.
	function automatic request_t random_request();
		request_t rq;
		int       pick;
		pick = $urandom_range(0, 99);
		rq = '{KIND_ENQ, pick_queue(), 8'($urandom), 8'($urandom)};
		if (pick < 45) begin
			rq.eid = pick_entry();
		end else if (pick < 77) begin
			rq.op = KIND_DEQ;
		end else if (pick < 88) begin
			rq.op = KIND_MOVE;
			rq.did = pick_queue();
		end else begin
			rq = request_t'($urandom);
		end
		return rq;
	endfunction

	// Presents one request word and waits until the block takes it, idling beforehand at
	// the given rate. The word is taken at an edge where start is high and busy is low;
	// busy is read just after the edge, before the block's own updates land. Start is only
	// ever assigned once per edge, so a word that follows straight on keeps it high.
	task automatic send_word(input request_t rq, input bit known, input response_t typed,
			input int idle_pct);
		response_t resp;
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		kind <= rq.op;
		queue_id <= rq.qid;
		entry_id <= rq.eid;
		dest_queue_id <= rq.did;
		do begin
			@(posedge clk);
		end while (busy);
		resp = apply_request(rq);
		owed_responses.push_back(known ? typed : resp);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t ns: %s is %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// Response checker. The block cannot be held off, so every cycle with done high is one
	// response word, taken at the edge that ends it.
	always @(posedge clk) begin : check_responses
		response_t want;
		if (arst_n && done) begin
			if (owed_responses.size() == 0) begin
				report_mismatch("unrequested response, status", status, 0);
			end else begin
				want = owed_responses.pop_front();
				if (result_entry !== want.entry) begin
					report_mismatch("result_entry", result_entry, want.entry);
				end
				if (status !== want.status) begin
					report_mismatch("status", status, want.status);
				end
			end
		end
	end

	initial begin : stimulus
		for (int q = 0; q < NUM_QUEUES; q++) begin
			head_of[q] = LINK_END;
			tail_of[q] = LINK_END;
		end
		for (int e = 0; e < NUM_ENTRIES; e++) begin
			next_of[e] = LINK_END;
			held[e] = 1'b0;
		end

		// Reset is held low from time zero and released on an edge; no clearing pass follows.
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, sent with no idling so that words follow one another directly.
		foreach (directed_plan[i]) begin
			send_word(directed_plan[i].rq, directed_plan[i].known, directed_plan[i].want, 0);
		end

		// Random part in three idling phases: light, heavy, none.
		for (int ph = 0; ph < 3; ph++) begin
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				send_word(random_request(), 1'b0, '0, sender_idle_pct[ph]);
			end
		end
		start <= 1'b0;

		// Wait for the last response, then long enough for any stray one to show up.
		while (owed_responses.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Watchdog: a time limit several times the slowest correct run even with every move
	// draining a full queue and the sender at its heaviest idling.
	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule
